[hdl/ppli_pkg.sv]
// ----------------------------------------------------------------------------
// Periodic piecewise-linear interpolator - shared definitions
// Widths, opcodes, controller states and the command/status words that
// pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ppli_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 16;
    localparam int VAL_W               = 16;
    localparam int INDEX_W             = 4;
    localparam int COUNT_W             = 5;
    localparam int MIN_POINTS          = 2;
    localparam int DIV_STEPS           = 16;
    localparam int DIV_CNT_W           = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] POINT_COUNT_RESET = COUNT_W'(MIN_POINTS);

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_WRAP_SEARCH,
        ST_MUL,
        ST_DIV_INIT,
        ST_DIV,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic load_write;
        logic query_start;
        logic pass_start;
        logic search;
        logic wrap;
        logic miss;
        logic mul;
        logic div_init;
        logic div_step;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic pass_done;
        logic found;
        logic div_done;
    } dp_sts_t;

endpackage

[hdl/ppli_dp.sv]
// ----------------------------------------------------------------------------
// Periodic piecewise-linear interpolator - datapath
// Breakpoint memories, segment search, multiplier, restoring divider,
// saturation and the result word register.
// ----------------------------------------------------------------------------
module ppli_dp #(
    parameter int TABLE_DEPTH = ppli_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic        [ppli_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic        [ppli_pkg::INDEX_W-1:0] point_index,
    input  logic        [ppli_pkg::VAL_W-1:0]   point_x,
    input  logic signed [ppli_pkg::VAL_W-1:0]   point_y,
    input  logic        [ppli_pkg::VAL_W-1:0]   orient_a,
    input  logic        [ppli_pkg::VAL_W-1:0]   orient_b,
    input  ppli_pkg::dp_cmd_t                   cmd,
    output ppli_pkg::dp_sts_t                   sts,
    output logic signed [ppli_pkg::VAL_W-1:0]   interp_value,
    output logic                                not_found
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int W  = ppli_pkg::VAL_W;

    logic [W-1:0] x_mem [TABLE_DEPTH];
    logic [W-1:0] y_mem [TABLE_DEPTH];

    logic [ppli_pkg::COUNT_W-1:0] point_count_reg;
    logic [CW-1:0]                act_cnt;
    logic [CW-1:0]                last_idx;

    logic [CW-1:0]   rd_idx_reg;
    logic [CW-1:0]   didx_reg;
    logic            dv_reg;
    logic            found_reg;
    logic            miss_reg;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;
    logic            wr_ok;
    logic [W-1:0]    rd_x_reg;
    logic [W-1:0]    rd_y_reg;
    logic [W-1:0]    prev_x_reg;
    logic [W-1:0]    prev_y_reg;
    logic signed [W+1:0] x_reg;
    logic [W-1:0]    xn_reg;
    logic [W-1:0]    xn1_reg;
    logic [W-1:0]    yn_reg;
    logic [W-1:0]    yn1_reg;
    logic            hit;
    logic [W-1:0]    abs_diff;

    logic signed [W:0]     dy;
    logic signed [W+1:0]   off_full;
    logic [W-1:0]          off;
    logic signed [2*W+1:0] prod_next;
    logic signed [2*W+1:0] prod_reg;
    logic [2*W+1:0]        mag;
    logic [W-1:0]          dx_reg;
    logic                  neg_reg;
    logic [W-1:0]          rem_reg;
    logic [W-1:0]          dvd_reg;
    logic [W-1:0]          quo_reg;
    logic [W:0]            shifted;
    logic [W+1:0]          trial;
    logic [ppli_pkg::DIV_CNT_W-1:0] div_cnt_reg;
    logic signed [W+1:0]   q_signed;
    logic signed [W+1:0]   sum;
    logic signed [W-1:0]   sat;

    logic signed [W-1:0]   interp_value_reg;
    logic                  not_found_reg;

    always_comb
    begin
        if (point_count_reg < ppli_pkg::COUNT_W'(ppli_pkg::MIN_POINTS))
            act_cnt = CW'(ppli_pkg::MIN_POINTS);
        else if (32'(point_count_reg) > TABLE_DEPTH)
            act_cnt = CW'(TABLE_DEPTH);
        else
            act_cnt = CW'(point_count_reg);
    end

    assign last_idx = act_cnt - 1'b1;
    assign wr_ok    = 32'(point_index) < TABLE_DEPTH;
    assign wr_addr  = AW'(point_index);
    assign rd_addr  = rd_idx_reg[AW-1:0];
    assign abs_diff = (orient_a > orient_b) ? orient_a - orient_b : orient_b - orient_a;

    assign hit = dv_reg && (didx_reg != '0)
              && ($signed({2'b00, prev_x_reg}) <= x_reg)
              && ($signed({2'b00, rd_x_reg}) > x_reg);

    assign sts.pass_done = dv_reg && (didx_reg == last_idx);
    assign sts.found     = found_reg || hit;
    assign sts.div_done  = div_cnt_reg == ppli_pkg::DIV_CNT_W'(ppli_pkg::DIV_STEPS - 1);

    // Memories
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && wr_ok)
        begin
            x_mem[wr_addr] <= point_x;
            y_mem[wr_addr] <= point_y;
        end
        rd_x_reg <= x_mem[rd_addr];
        rd_y_reg <= y_mem[rd_addr];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= ppli_pkg::POINT_COUNT_RESET;
            rd_idx_reg      <= '0;
            didx_reg        <= '0;
            dv_reg          <= 1'b0;
            found_reg       <= 1'b0;
            miss_reg        <= 1'b0;
            div_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
                point_count_reg <= cfg_wr_data;

            if (cmd.pass_start)
            begin
                rd_idx_reg <= '0;
                dv_reg     <= 1'b0;
            end
            else if (cmd.search)
            begin
                if (rd_idx_reg < act_cnt)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                    didx_reg   <= rd_idx_reg;
                    dv_reg     <= 1'b1;
                end
                else
                begin
                    dv_reg <= 1'b0;
                end
            end

            if (cmd.query_start)
                found_reg <= 1'b0;
            else if (cmd.search && hit)
                found_reg <= 1'b1;

            if (cmd.query_start)
                miss_reg <= 1'b0;
            else if (cmd.miss)
                miss_reg <= 1'b1;

            if (cmd.div_init)
                div_cnt_reg <= '0;
            else if (cmd.div_step)
                div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Arithmetic
    assign dy        = $signed({yn1_reg[W-1], yn1_reg}) - $signed({yn_reg[W-1], yn_reg});
    assign off_full  = x_reg - $signed({2'b00, xn_reg});
    assign off       = off_full[W-1:0];
    assign prod_next = (2*W+2)'(dy * $signed({1'b0, off}));
    assign mag       = prod_reg[2*W+1] ? (2*W+2)'(-prod_reg) : prod_reg;
    assign shifted   = {rem_reg, dvd_reg[W-1]};
    assign trial     = {1'b0, shifted} - {2'b00, dx_reg};
    assign q_signed  = neg_reg ? -$signed({2'b00, quo_reg}) : $signed({2'b00, quo_reg});
    assign sum       = q_signed + $signed({{2{yn_reg[W-1]}}, yn_reg});

    always_comb
    begin
        if (sum > $signed((W+2)'(32767)))
            sat = 16'sh7FFF;
        else if (sum < -$signed((W+2)'(32768)))
            sat = 16'sh8000;
        else
            sat = sum[W-1:0];
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
            x_reg <= $signed({2'b00, abs_diff});
        else if (cmd.wrap)
            x_reg <= x_reg - $signed({2'b00, rd_x_reg});

        if (dv_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
        end

        if (cmd.search && hit)
        begin
            xn_reg  <= prev_x_reg;
            xn1_reg <= rd_x_reg;
            yn_reg  <= prev_y_reg;
            yn1_reg <= rd_y_reg;
        end

        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            dx_reg   <= xn1_reg - xn_reg;
        end

        if (cmd.div_init)
        begin
            neg_reg <= prod_reg[2*W+1];
            rem_reg <= mag[2*W-1:W];
            dvd_reg <= mag[W-1:0];
            quo_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            dvd_reg <= {dvd_reg[W-2:0], 1'b0};
            if (!trial[W+1])
            begin
                rem_reg <= trial[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[W-1:0];
                quo_reg <= {quo_reg[W-2:0], 1'b0};
            end
        end

        if (cmd.out_load)
        begin
            interp_value_reg <= miss_reg ? '0 : sat;
            not_found_reg    <= miss_reg;
        end
    end

    assign interp_value = interp_value_reg;
    assign not_found    = not_found_reg;

endmodule

[hdl/ppli_ctrl.sv]
// ----------------------------------------------------------------------------
// Periodic piecewise-linear interpolator - controller
// Sequences load, search, wrap, multiply, divide and result hand-off.
// ----------------------------------------------------------------------------
module ppli_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              opcode,
    output logic              out_valid,
    input  logic              out_ready,
    input  ppli_pkg::dp_sts_t sts,
    output ppli_pkg::dp_cmd_t cmd
);

    ppli_pkg::ctrl_state_t state_reg;
    ppli_pkg::ctrl_state_t state_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ppli_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;

        case (state_reg)
            ppli_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (opcode == ppli_pkg::OP_QUERY)
                    begin
                        cmd.query_start = 1'b1;
                        cmd.pass_start  = 1'b1;
                        state_next      = ppli_pkg::ST_SEARCH;
                    end
                    else
                    begin
                        cmd.load_write = 1'b1;
                    end
                end
            end
            ppli_pkg::ST_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.pass_done)
                begin
                    if (sts.found)
                        state_next = ppli_pkg::ST_MUL;
                    else
                    begin
                        cmd.wrap       = 1'b1;
                        cmd.pass_start = 1'b1;
                        state_next     = ppli_pkg::ST_WRAP_SEARCH;
                    end
                end
            end
            ppli_pkg::ST_WRAP_SEARCH:
            begin
                cmd.search = 1'b1;
                if (sts.pass_done)
                begin
                    if (sts.found)
                        state_next = ppli_pkg::ST_MUL;
                    else
                    begin
                        cmd.miss   = 1'b1;
                        state_next = ppli_pkg::ST_FINISH;
                    end
                end
            end
            ppli_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ppli_pkg::ST_DIV_INIT;
            end
            ppli_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                state_next   = ppli_pkg::ST_DIV;
            end
            ppli_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_done)
                    state_next = ppli_pkg::ST_FINISH;
            end
            ppli_pkg::ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ppli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ppli_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[hdl/periodic_piecewise_linear_interp.sv]
// ----------------------------------------------------------------------------
// Periodic piecewise-linear interpolator - top level
// Load items write one breakpoint; query items return one interpolated word.
// ----------------------------------------------------------------------------
// Load word: no result; the controller stays idle, so the next word is taken the cycle after.
// Query word with N active points: a search pass over the N entries, plus a second pass
// after the periodic wrap when the first finds no segment, then multiply, divider setup,
// 16 divide steps and result load; a miss after the wrap goes straight to result load.
// The search reads one memory entry per cycle; the divider yields one bit per cycle.
// Reset: point_count returns to 2; breakpoint memories keep no reset contents.
module periodic_piecewise_linear_interp #(
    parameter int TABLE_DEPTH = ppli_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic        [ppli_pkg::COUNT_W-1:0] cfg_wr_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                opcode,
    input  logic        [ppli_pkg::INDEX_W-1:0] point_index,
    input  logic        [ppli_pkg::VAL_W-1:0]   point_x,
    input  logic signed [ppli_pkg::VAL_W-1:0]   point_y,
    input  logic        [ppli_pkg::VAL_W-1:0]   orient_a,
    input  logic        [ppli_pkg::VAL_W-1:0]   orient_b,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [ppli_pkg::VAL_W-1:0]   interp_value,
    output logic                                not_found
);

    ppli_pkg::dp_cmd_t cmd;
    ppli_pkg::dp_sts_t sts;

    ppli_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .opcode    (opcode),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ppli_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .point_index  (point_index),
        .point_x      (point_x),
        .point_y      (point_y),
        .orient_a     (orient_a),
        .orient_b     (orient_b),
        .cmd          (cmd),
        .sts          (sts),
        .interp_value (interp_value),
        .not_found    (not_found)
    );

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && not_found |-> interp_value == '0)
        else $error("not_found word carries a nonzero value");

    a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && opcode == ppli_pkg::OP_QUERY |=> !in_ready)
        else $error("query word did not start the search sequence");

    a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> in_ready)
        else $error("result loaded without returning to idle");

    a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.mul, cmd.div_init, cmd.div_step, cmd.out_load, cmd.search}))
        else $error("conflicting datapath commands");

endmodule
